[rtl/psar_pkg.sv]
// Shared kinds, item and result types for the scroll and address register block.
`default_nettype none
package psar_pkg;

  localparam int KindW = 4;
  localparam int DataW = 8;
  localparam int AddrW = 15;
  localparam int BusW  = 14;

  localparam logic [KindW-1:0] KIND_CTRL_WR   = 4'd0;
  localparam logic [KindW-1:0] KIND_SCROLL_WR = 4'd1;
  localparam logic [KindW-1:0] KIND_ADDR_WR   = 4'd2;
  localparam logic [KindW-1:0] KIND_DATA_ACC  = 4'd3;
  localparam logic [KindW-1:0] KIND_STATUS_RD = 4'd4;
  localparam logic [KindW-1:0] KIND_STEP_X    = 4'd5;
  localparam logic [KindW-1:0] KIND_STEP_Y    = 4'd6;
  localparam logic [KindW-1:0] KIND_COPY_X    = 4'd7;
  localparam logic [KindW-1:0] KIND_COPY_Y    = 4'd8;

  localparam logic [AddrW-1:0] MASK_COPY_X   = 15'h041F;
  localparam logic [AddrW-1:0] MASK_COPY_Y   = 15'h7BE0;
  localparam logic [BusW-1:0]  TILE_BASE     = 14'h2000;
  localparam logic [BusW-1:0]  ATTR_BASE     = 14'h23C0;
  localparam logic [4:0]       ROW_LAST_VIS  = 5'h1D;
  localparam logic [4:0]       ROW_LAST      = 5'h1F;

  localparam int ResW = 64;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [DataW-1:0] data;
  } item_t;

  // Packed first field highest: toggle ends up on the top bit.
  typedef struct packed {
    logic            toggle;
    logic [2:0]      fine_y;
    logic [2:0]      fine_x;
    logic [BusW-1:0] attr_addr;
    logic [BusW-1:0] tile_addr;
    logic [AddrW-1:0] addr_after;
    logic [BusW-1:0] used_addr;
  } result_t;

endpackage
`default_nettype wire

[rtl/ppu_scroll_address_registers.sv]
// Top level: input register, scroll/address state update, result register.
// A beat is held in the input register, then its result is registered in the
// result register that drives m_tdata.
// Throughput: one beat per cycle while m_tready is high; the state update is a single
// pass of bit logic and one 15-bit add, done as the beat leaves the input register.
// Reset (rst, synchronous) empties both registered stages and clears all scroll and
// address state to zero.
`default_nettype none
module ppu_scroll_address_registers
  import psar_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data
  input  wire logic [3:0]  s_tuser,   // [3:0] kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata    // [13:0] used_addr, [28:14] addr_after,
                                      // [42:29] tile_addr, [56:43] attr_addr,
                                      // [59:57] fine_x, [62:60] fine_y, [63] toggle
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    res_ready;
  logic    fire;
  result_t result;

  assign in_item.kind = s_tuser;
  assign in_item.data = s_tdata;
  assign fire         = item_valid && res_ready;

  psar_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (res_ready),
    .item       (item)
  );

  psar_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  psar_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (item_valid),
    .res_ready (res_ready),
    .res       (result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
`default_nettype wire

[rtl/psar_in_stage.sv]
// Input register: holds one accepted beat until the register stage takes it.
`default_nettype none
module psar_in_stage
  import psar_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       item_valid,
  input  wire logic  item_take,
  output item_t      item
);

  logic  valid;
  item_t held;

  assign in_ready   = !valid || item_take;
  assign item_valid = valid;
  assign item       = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      held <= in_item;
    end
  end

endmodule
`default_nettype wire

[rtl/psar_regs.sv]
// Scroll and address state with its update logic; forms the result of each item.
`default_nettype none
module psar_regs
  import psar_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  fire,
  input  wire item_t item,
  output result_t    result
);

  logic [AddrW-1:0] temp_addr, temp_addr_next;
  logic [AddrW-1:0] cur_addr, cur_addr_next;
  logic [2:0]       fine_scroll_x, fine_scroll_x_next;
  logic             second_write, second_write_next;
  logic             step_by_row, step_by_row_next;
  logic [BusW-1:0]  used;
  logic [AddrW-1:0] step_x_addr;
  logic [AddrW-1:0] step_y_addr;
  logic [4:0]       row;
  logic [AddrW-1:0] acc_step;

  // Coarse x wraps into the neighboring horizontal table.
  always_comb begin
    step_x_addr = cur_addr;
    if (cur_addr[4:0] == 5'h1F) begin
      step_x_addr[4:0] = 5'd0;
      step_x_addr[10]  = ~cur_addr[10];
    end else begin
      step_x_addr[4:0] = cur_addr[4:0] + 5'd1;
    end
  end

  // Fine y rolls into coarse y; row 29 flips the vertical table, row 31 wraps alone.
  always_comb begin
    row         = cur_addr[9:5];
    step_y_addr = cur_addr;
    if (cur_addr[14:12] != 3'd7) begin
      step_y_addr[14:12] = cur_addr[14:12] + 3'd1;
    end else begin
      step_y_addr[14:12] = 3'd0;
      if (row == ROW_LAST_VIS) begin
        step_y_addr[9:5] = 5'd0;
        step_y_addr[11]  = ~cur_addr[11];
      end else if (row == ROW_LAST) begin
        step_y_addr[9:5] = 5'd0;
      end else begin
        step_y_addr[9:5] = row + 5'd1;
      end
    end
  end

  assign acc_step = step_by_row ? 15'd32 : 15'd1;

  always_comb begin
    temp_addr_next     = temp_addr;
    cur_addr_next      = cur_addr;
    fine_scroll_x_next = fine_scroll_x;
    second_write_next  = second_write;
    step_by_row_next   = step_by_row;
    used               = '0;
    unique case (item.kind)
      KIND_CTRL_WR: begin
        temp_addr_next[11:10] = item.data[1:0];
        step_by_row_next      = item.data[2];
      end
      KIND_SCROLL_WR: begin
        if (!second_write) begin
          temp_addr_next[4:0] = item.data[7:3];
          fine_scroll_x_next  = item.data[2:0];
          second_write_next   = 1'b1;
        end else begin
          temp_addr_next[14:12] = item.data[2:0];
          temp_addr_next[9:5]   = item.data[7:3];
          second_write_next     = 1'b0;
        end
      end
      KIND_ADDR_WR: begin
        if (!second_write) begin
          temp_addr_next[14]   = 1'b0;
          temp_addr_next[13:8] = item.data[5:0];
          second_write_next    = 1'b1;
        end else begin
          temp_addr_next[7:0] = item.data;
          cur_addr_next       = {temp_addr[14:8], item.data};
          second_write_next   = 1'b0;
        end
      end
      KIND_DATA_ACC: begin
        used          = cur_addr[BusW-1:0];
        cur_addr_next = cur_addr + acc_step;
      end
      KIND_STATUS_RD: second_write_next = 1'b0;
      KIND_STEP_X:    cur_addr_next = step_x_addr;
      KIND_STEP_Y:    cur_addr_next = step_y_addr;
      KIND_COPY_X:    cur_addr_next = (cur_addr & ~MASK_COPY_X) | (temp_addr & MASK_COPY_X);
      KIND_COPY_Y:    cur_addr_next = (cur_addr & ~MASK_COPY_Y) | (temp_addr & MASK_COPY_Y);
      default: ;
    endcase
  end

  always_comb begin
    result.used_addr  = used;
    result.addr_after = cur_addr_next;
    result.tile_addr  = TILE_BASE | {2'b00, cur_addr_next[11:0]};
    result.attr_addr  = ATTR_BASE | {2'b00, cur_addr_next[11:10], 4'b0000,
                                     cur_addr_next[9:7], cur_addr_next[4:2]};
    result.fine_x     = fine_scroll_x_next;
    result.fine_y     = cur_addr_next[14:12];
    result.toggle     = second_write_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_addr     <= '0;
      cur_addr      <= '0;
      fine_scroll_x <= '0;
      second_write  <= 1'b0;
      step_by_row   <= 1'b0;
    end else if (fire) begin
      temp_addr     <= temp_addr_next;
      cur_addr      <= cur_addr_next;
      fine_scroll_x <= fine_scroll_x_next;
      second_write  <= second_write_next;
      step_by_row   <= step_by_row_next;
    end
  end

endmodule
`default_nettype wire

[rtl/psar_out_stage.sv]
// Result register: holds a finished result until the downstream side takes it.
`default_nettype none
module psar_out_stage
  import psar_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    res_valid,
  output logic         res_ready,
  input  wire result_t res,
  output logic         out_valid,
  input  wire logic    out_ready,
  output logic [ResW-1:0] out_data
);

  logic    valid;
  result_t held;

  assign res_ready = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_ready) begin
      valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      held <= res;
    end
  end

endmodule
`default_nettype wire

[verif/scroll_addr_checker.sv]
`timescale 1ns / 1ps
// Watches both channels of the scroll and address block, predicts each result and compares.
module scroll_addr_checker
  import psar_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [3:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  output int          fail_count,
  output int          pending
);

  // Predicted register state
  logic [AddrW-1:0] tmp_vaddr;
  logic [AddrW-1:0] cur_vaddr;
  logic [2:0]       fine_x_q;
  logic             second_wr;
  logic             row_step;

  result_t pending_results[$];
  int      mismatches = 0;

  function automatic result_t apply_scroll_item(input logic [KindW-1:0] kind,
                                                input logic [DataW-1:0] data);
    result_t    r;
    logic [4:0] row;
    r = '0;
    case (kind)
      KIND_CTRL_WR: begin
        tmp_vaddr[11:10] = data[1:0];
        row_step = data[2];
      end
      KIND_SCROLL_WR: begin
        if (!second_wr) begin
          tmp_vaddr[4:0] = data[7:3];
          fine_x_q = data[2:0];
          second_wr = 1'b1;
        end else begin
          tmp_vaddr[14:12] = data[2:0];
          tmp_vaddr[9:5] = data[7:3];
          second_wr = 1'b0;
        end
      end
      KIND_ADDR_WR: begin
        if (!second_wr) begin
          // first write drops bit 14
          tmp_vaddr[14] = 1'b0;
          tmp_vaddr[13:8] = data[5:0];
          second_wr = 1'b1;
        end else begin
          tmp_vaddr[7:0] = data;
          cur_vaddr = tmp_vaddr;
          second_wr = 1'b0;
        end
      end
      KIND_DATA_ACC: begin
        r.used_addr = cur_vaddr[13:0];
        cur_vaddr = cur_vaddr + (row_step ? 15'd32 : 15'd1);
      end
      KIND_STATUS_RD: second_wr = 1'b0;
      KIND_STEP_X: begin
        if (cur_vaddr[4:0] == 5'h1F) begin
          cur_vaddr[4:0] = 5'h00;
          cur_vaddr[10] = ~cur_vaddr[10];
        end else begin
          cur_vaddr = cur_vaddr + 15'd1;
        end
      end
      KIND_STEP_Y: begin
        if (cur_vaddr[14:12] != 3'd7) begin
          cur_vaddr[14:12] = cur_vaddr[14:12] + 3'd1;
        end else begin
          cur_vaddr[14:12] = 3'd0;
          row = cur_vaddr[9:5];
          // last visible row flips the vertical table, the last row just wraps
          if (row == ROW_LAST_VIS) begin
            row = 5'd0;
            cur_vaddr[11] = ~cur_vaddr[11];
          end else if (row == ROW_LAST) begin
            row = 5'd0;
          end else begin
            row = row + 5'd1;
          end
          cur_vaddr[9:5] = row;
        end
      end
      KIND_COPY_X: cur_vaddr = (cur_vaddr & ~MASK_COPY_X) | (tmp_vaddr & MASK_COPY_X);
      KIND_COPY_Y: cur_vaddr = (cur_vaddr & MASK_COPY_X) | (tmp_vaddr & MASK_COPY_Y);
      default: ;
    endcase
    r.addr_after = cur_vaddr;
    r.tile_addr  = TILE_BASE | {2'b00, cur_vaddr[11:0]};
    r.attr_addr  = ATTR_BASE | {2'b00, cur_vaddr[11:10], 4'b0000, cur_vaddr[9:7],
                                cur_vaddr[4:2]};
    r.fine_x     = fine_x_q;
    r.fine_y     = cur_vaddr[14:12];
    r.toggle     = second_wr;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [14:0] want,
                             input logic [14:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      tmp_vaddr = '0;
      cur_vaddr = '0;
      fine_x_q  = '0;
      second_wr = 1'b0;
      row_step  = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_results.size() == 0) begin
          $error("result beat %0h arrived with nothing expected", m_tdata);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("used_addr", 15'(want.used_addr), 15'(got.used_addr));
          check_field("addr_after", want.addr_after, got.addr_after);
          check_field("tile_addr", 15'(want.tile_addr), 15'(got.tile_addr));
          check_field("attr_addr", 15'(want.attr_addr), 15'(got.attr_addr));
          check_field("fine_x", 15'(want.fine_x), 15'(got.fine_x));
          check_field("fine_y", 15'(want.fine_y), 15'(got.fine_y));
          check_field("toggle", 15'(want.toggle), 15'(got.toggle));
        end
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(apply_scroll_item(s_tuser, s_tdata));
    end
    fail_count <= mismatches;
    pending    <= pending_results.size();
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top: drives beats into the scroll and address block and reports the verdict.
module tb_top;
  import psar_pkg::*;

  localparam logic [KindW-1:0] KIND_SPARE_LO = 4'd9;
  localparam logic [KindW-1:0] KIND_SPARE_HI = 4'd15;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [3:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic long_hold = 1'b0;
  int hold_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ppu_scroll_address_registers i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  scroll_addr_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver: random stalls, or a counted hold-off while long_hold is up
  always @(posedge clk) begin
    if (long_hold && hold_count < HOLD_CYCLES) begin
      m_tready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
      if (!long_hold)
        hold_count <= 0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic send_beat(input logic [KindW-1:0] kind, input logic [DataW-1:0] data);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_random(input int count);
    logic [KindW-1:0] kind;
    repeat (count) begin
      if ($urandom_range(99) < 8)
        kind = KindW'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
      else
        kind = KindW'($urandom_range(KIND_COPY_Y, KIND_CTRL_WR));
      send_beat(kind, DataW'($urandom_range(255)));
    end
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Build a current address of all ones, wrap it with the row step, then step by one
    send_beat(KIND_CTRL_WR, 8'hFF);
    send_beat(KIND_SCROLL_WR, 8'hFF);
    send_beat(KIND_SCROLL_WR, 8'hFF);
    send_beat(KIND_COPY_X, 8'h00);
    send_beat(KIND_COPY_Y, 8'h00);
    send_beat(KIND_DATA_ACC, 8'h00);
    send_beat(KIND_CTRL_WR, 8'h00);
    send_beat(KIND_COPY_Y, 8'h00);
    send_beat(KIND_COPY_X, 8'h00);
    send_beat(KIND_DATA_ACC, 8'hFF);
    // Coarse x wrap flips the horizontal table
    send_beat(KIND_COPY_X, 8'h00);
    send_beat(KIND_STEP_X, 8'h00);
    // Vertical step at the last visible row, then at the last row
    send_beat(KIND_SCROLL_WR, 8'h05);
    send_beat(KIND_SCROLL_WR, 8'hEF);
    send_beat(KIND_COPY_Y, 8'h00);
    send_beat(KIND_STEP_Y, 8'h00);
    send_beat(KIND_SCROLL_WR, 8'h00);
    send_beat(KIND_SCROLL_WR, 8'hFF);
    send_beat(KIND_COPY_Y, 8'h00);
    send_beat(KIND_STEP_Y, 8'h00);
    send_beat(KIND_STEP_Y, 8'h00);
    // Address writes around a status read
    send_beat(KIND_ADDR_WR, 8'hFF);
    send_beat(KIND_STATUS_RD, 8'h00);
    send_beat(KIND_ADDR_WR, 8'hC0);
    send_beat(KIND_ADDR_WR, 8'hAA);
    send_beat(KIND_SPARE_HI, 8'hFF);
    send_beat(KIND_SPARE_LO, 8'h00);
    drain();

    // No idling
    send_random(175);
    // Sender idle
    tx_idle_pct = 68;
    send_random(175);
    drain();
    // Receiver stalling
    tx_idle_pct = 0;
    rx_stall_pct <= 68;
    send_random(175);
    // Both sides idling
    tx_idle_pct = 36;
    rx_stall_pct <= 36;
    send_random(175);
    // Long hold-off on the receiver while the sender keeps offering beats
    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    long_hold <= 1'b1;
    send_random(40);
    long_hold <= 1'b0;
    drain();

    repeat (6) @(posedge clk);
    if (fail_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

[files.f]
rtl/psar_pkg.sv
rtl/psar_in_stage.sv
rtl/psar_regs.sv
rtl/psar_out_stage.sv
rtl/ppu_scroll_address_registers.sv
verif/scroll_addr_checker.sv
verif/tb_top.sv
